// ===== design/odc_pkg.sv =====
// Package for the ordering discipline classifier: sizes, verdict codes,
// heap sequencer states and shared structs. No dependencies.
package odc_pkg;
  localparam int Depth = 1024;
  localparam int DataWidth = 16;
  localparam int AddrWidth = $clog2(Depth);
  localparam int CountWidth = AddrWidth + 1;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [AddrWidth-1:0] addr_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [2:0] {
    VerdictImpossible = 3'd0,
    VerdictStack      = 3'd1,
    VerdictQueue      = 3'd2,
    VerdictPriority   = 3'd3,
    VerdictNotSure    = 3'd4
  } verdict_t;

  typedef enum logic [3:0] {
    HpIdle,
    HpUpRead,
    HpUpCmp,
    HpDnTop,
    HpDnLast,
    HpDnReadL,
    HpDnReadR,
    HpDnCmp,
    HpDone
  } heap_state_t;

  typedef struct packed {
    logic start;
    logic is_pop;
    data_t value;
  } heap_req_t;

  typedef struct packed {
    logic done;
    logic top_match;
  } heap_rsp_t;
endpackage

// ===== design/odc_heap.sv =====
// Max-heap model held in one synchronous memory; sifts up on a push and
// down on a pop, one level at a time. Depends on odc_pkg.
module odc_heap (
  input  logic               clk,
  input  logic               rst,
  input  logic               clear,
  input  odc_pkg::heap_req_t req,
  output odc_pkg::heap_rsp_t rsp
);
  import odc_pkg::*;

  data_t mem [Depth];
  data_t rdata;
  addr_t raddr;
  logic  we;
  addr_t waddr;
  data_t wdata;

  heap_state_t state, state_next;
  count_t count;
  addr_t idx;
  addr_t parent;
  data_t val;
  data_t left;
  logic  match;
  count_t cl, cr;
  logic  take_right;
  data_t child_val;
  addr_t child_idx;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign parent = (idx - addr_t'(1)) >> 1;
  assign cl = {idx, 1'b1};
  assign cr = {idx, 1'b0} + count_t'(2);

  // In the compare state rdata holds the right child and left the left one.
  assign take_right = (cr < count) && (rdata > left);
  assign child_val = take_right ? rdata : left;
  assign child_idx = take_right ? addr_t'(cr) : addr_t'(cl);

  always_comb begin
    state_next = state;
    case (state)
      HpIdle: begin
        if (req.start) begin
          if (!req.is_pop) state_next = HpUpRead;
          else if (count == '0) state_next = HpDone;
          else state_next = HpDnTop;
        end
      end
      HpUpRead: state_next = (idx == '0) ? HpDone : HpUpCmp;
      HpUpCmp: state_next = (rdata >= val) ? HpDone : HpUpRead;
      HpDnTop: state_next = (count == '0) ? HpDone : HpDnLast;
      HpDnLast: state_next = HpDnReadL;
      HpDnReadL: state_next = (cl >= count) ? HpDone : HpDnReadR;
      HpDnReadR: state_next = HpDnCmp;
      HpDnCmp: state_next = (child_val > val) ? HpDnReadL : HpDone;
      HpDone: state_next = HpIdle;
      default: state_next = HpIdle;
    endcase
  end

  // Memory address and write selection per state. Idle keeps the top
  // addressed so that a pop finds it in the data register.
  always_comb begin
    raddr = '0;
    we = 1'b0;
    waddr = idx;
    wdata = val;
    case (state)
      HpUpRead: begin
        raddr = parent;
        we = (idx == '0);
      end
      HpUpCmp: begin
        we = 1'b1;
        if (rdata < val) wdata = rdata;
      end
      HpDnTop: raddr = addr_t'(count);
      HpDnReadL: begin
        raddr = addr_t'(cl);
        we = (cl >= count);
      end
      HpDnReadR: raddr = addr_t'(cr);
      HpDnCmp: begin
        we = 1'b1;
        if (child_val > val) wdata = child_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HpIdle;
      count <= '0;
      idx <= '0;
      val <= '0;
      left <= '0;
      match <= 1'b0;
    end else begin
      state <= state_next;
      if (clear) begin
        count <= '0;
      end else if (state == HpIdle && req.start) begin
        if (!req.is_pop) count <= count + 1'b1;
        else if (count != '0) count <= count - 1'b1;
      end
      case (state)
        HpIdle: begin
          if (req.start) begin
            val <= req.value;
            idx <= addr_t'(count);
            match <= 1'b0;
          end
        end
        HpUpCmp: if (rdata < val) idx <= parent;
        HpDnTop: match <= (rdata == val);
        HpDnLast: begin
          val <= rdata;
          idx <= '0;
        end
        HpDnReadR: left <= rdata;
        HpDnCmp: if (child_val > val) idx <= child_idx;
        default: ;
      endcase
    end
  end

  assign rsp.done = (state == HpDone);
  assign rsp.top_match = match;
endmodule

// ===== design/odc_lists.sv =====
// Stack and queue models, each in its own synchronous memory, with the
// head read in the cycle before the compare. Depends on odc_pkg.
module odc_lists (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          start,
  input  logic          is_pop,
  input  odc_pkg::data_t value,
  output logic          stack_hit,
  output logic          queue_hit,
  output logic          stack_empty,
  output logic          queue_empty,
  output logic          full
);
  import odc_pkg::*;

  data_t lifo_mem [Depth];
  data_t fifo_mem [Depth];
  data_t lifo_q, fifo_q;
  count_t lifo_count, fifo_count;
  addr_t head, tail;
  logic do_push;

  assign stack_empty = (lifo_count == 0);
  assign queue_empty = (fifo_count == 0);
  assign full = (lifo_count == count_t'(Depth));
  assign do_push = start && !is_pop && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      lifo_mem[lifo_count[AddrWidth-1:0]] <= value;
      fifo_mem[tail] <= value;
    end
    lifo_q <= lifo_mem[addr_t'(lifo_count - 1'b1)];
    fifo_q <= fifo_mem[head];
  end

  // Heads were registered the cycle the request arrived; compare next cycle.
  assign stack_hit = (lifo_q == value);
  assign queue_hit = (fifo_q == value);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      lifo_count <= '0;
      fifo_count <= '0;
      head <= '0;
      tail <= '0;
    end else if (do_push) begin
      lifo_count <= lifo_count + 1'b1;
      fifo_count <= fifo_count + 1'b1;
      tail <= tail + 1'b1;
    end else if (start && is_pop) begin
      if (!stack_empty) lifo_count <= lifo_count - 1'b1;
      if (!queue_empty) begin
        fifo_count <= fifo_count - 1'b1;
        head <= head + 1'b1;
      end
    end
  end
endmodule

// ===== design/ordering_discipline_classifier.sv =====
// Top level of the ordering discipline classifier: request handshake,
// match flags and verdict. Depends on odc_pkg, odc_lists and odc_heap.
//
// Each push or pop request is mirrored into a stack, a queue and a max-heap,
// each kept in a 1024-entry synchronous memory. One request is handled at a
// time. The heap walk through its single memory port sets how long it takes:
// a push climbs toward the top of the heap and a pop sifts down toward a
// leaf. A push that overflows and a pop on empty models skip the walk. The
// result is held in an output register and the next request is taken in the
// cycle the result appears. The input stays stalled while a request is in
// progress, also while its result waits for the output register to be free.
module ordering_discipline_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // value
  input  logic        s_tuser,   // cmd
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // stack_ok, queue_ok, heap_ok, verdict[2:0], overflow, 0
);
  import odc_pkg::*;

  logic busy, first, cmd, last, ovf, ovf_q, done_q;
  data_t value;
  logic [2:0] flags, f;
  heap_req_t hreq;
  heap_rsp_t hrsp;
  logic stack_hit, queue_hit, s_empty, q_empty, lfull;
  logic stack_e0, queue_e0, hit_s, hit_q;
  logic clear, out_free, fin, accept;
  verdict_t verdict;

  assign accept = s_tvalid && s_tready;
  assign s_tready = !busy;

  assign hreq.start = first && !ovf;
  assign hreq.is_pop = cmd;
  assign hreq.value = value;

  odc_lists u_lists (
    .clk, .rst, .clear,
    .start(first && !ovf), .is_pop(cmd), .value,
    .stack_hit, .queue_hit, .stack_empty(s_empty), .queue_empty(q_empty),
    .full(lfull)
  );

  odc_heap u_heap (.clk, .rst, .clear, .req(hreq), .rsp(hrsp));

  assign ovf = !cmd && lfull;

  // Apply the pop compare to the flags once the heap finishes.
  always_comb begin
    f = flags;
    if (cmd) begin
      if (stack_e0 || !hit_s) f[0] = 1'b0;
      if (queue_e0 || !hit_q) f[1] = 1'b0;
      if (!hrsp.top_match) f[2] = 1'b0;
    end
  end

  always_comb begin
    case (f)
      3'b000: verdict = VerdictImpossible;
      3'b001: verdict = VerdictStack;
      3'b010: verdict = VerdictQueue;
      3'b100: verdict = VerdictPriority;
      default: verdict = VerdictNotSure;
    endcase
  end

  // A request finishes once its heap walk is over (or it was dropped) and the
  // output register is free to take the result.
  assign out_free = !m_tvalid || m_tready;
  assign fin = busy && !first && (ovf_q || hrsp.done || done_q) && out_free;
  assign clear = fin && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      first <= 1'b0;
      done_q <= 1'b0;
      m_tvalid <= 1'b0;
      flags <= 3'b111;
    end else begin
      first <= accept;
      if (accept) busy <= 1'b1;
      else if (fin) busy <= 1'b0;
      if (fin) done_q <= 1'b0;
      else if (hrsp.done) done_q <= 1'b1;
      if (fin) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (fin) flags <= last ? 3'b111 : f;
    end
  end

  // The stack and queue heads were read at the accepting edge, so they are
  // compared, together with the empty flags, in the cycle after it.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= s_tuser;
      value <= s_tdata;
      last <= s_tlast;
    end
    if (first) begin
      ovf_q <= ovf;
      stack_e0 <= s_empty;
      queue_e0 <= q_empty;
      hit_s <= stack_hit;
      hit_q <= queue_hit;
    end
    if (fin) m_tdata <= {1'b0, ovf_q, verdict, f[2], f[1], f[0]};
  end
endmodule

// ===== tb/tb_ordering_discipline_classifier.sv =====
// Self-checking testbench for ordering_discipline_classifier: a directed table
// followed by random push/pop traces, checked against an in-bench predictor.
// Depends on odc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_ordering_discipline_classifier;
  import odc_pkg::*;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;
  localparam int   TotalRequests = 400;

  // A result as the block packs it into m_tdata[6:0], highest field first.
  typedef struct packed {
    logic     overflow;
    verdict_t verdict;
    logic     heap_ok;
    logic     queue_ok;
    logic     stack_ok;
  } answer_t;

  // One row of the directed table; has_fixed marks a typed-in answer.
  typedef struct {
    logic    cmd;
    data_t   value;
    logic    last;
    logic    has_fixed;
    answer_t fixed;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // value
  logic        s_tuser = 1'b0; // cmd
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // stack_ok, queue_ok, heap_ok, verdict[2:0], overflow, 0

  ordering_discipline_classifier u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Predictor state: three mirrored orderings and the match flags.
  data_t   stack_mem[$];
  data_t   queue_mem[$];
  data_t   heap_mem[Depth];
  int      heap_fill;
  logic [2:0] flags;

  answer_t expected_answers[$];
  int      mismatches = 0;
  int      answers_seen = 0;
  int      pops_sent = 0;
  int      requests_sent = 0;
  logic    use_fixed = 1'b0;
  answer_t fixed_answer = '0;

  function automatic void clear_orderings();
    stack_mem.delete();
    queue_mem.delete();
    heap_fill = 0;
    flags = 3'b111;
  endfunction

  function automatic void heap_push(data_t v);
    int i;
    int p;
    i = heap_fill;
    heap_fill++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_mem[p] >= v) break;
      heap_mem[i] = heap_mem[p];
      i = p;
    end
    heap_mem[i] = v;
  endfunction

  function automatic void heap_drop_top();
    data_t v;
    int i;
    int c;
    i = 0;
    heap_fill--;
    if (heap_fill == 0) return;
    v = heap_mem[heap_fill];
    forever begin
      c = 2 * i + 1;
      if (c >= heap_fill) break;
      if (c + 1 < heap_fill && heap_mem[c + 1] > heap_mem[c]) c++;
      if (heap_mem[c] <= v) break;
      heap_mem[i] = heap_mem[c];
      i = c;
    end
    heap_mem[i] = v;
  endfunction

  // Works out the answer to one request and advances the predictor.
  function automatic answer_t classify(logic cmd, data_t v, logic last);
    answer_t a;
    a.overflow = 1'b0;
    if (cmd == CmdPush) begin
      if (stack_mem.size() >= Depth) a.overflow = 1'b1;
      else begin
        stack_mem.push_back(v);
        queue_mem.push_back(v);
        heap_push(v);
      end
    end else begin
      if (stack_mem.size() == 0) flags[0] = 1'b0;
      else if (stack_mem.pop_back() != v) flags[0] = 1'b0;
      if (queue_mem.size() == 0) flags[1] = 1'b0;
      else if (queue_mem.pop_front() != v) flags[1] = 1'b0;
      if (heap_fill == 0) flags[2] = 1'b0;
      else begin
        if (heap_mem[0] != v) flags[2] = 1'b0;
        heap_drop_top();
      end
    end
    a.stack_ok = flags[0];
    a.queue_ok = flags[1];
    a.heap_ok  = flags[2];
    case (flags)
      3'b000:  a.verdict = VerdictImpossible;
      3'b001:  a.verdict = VerdictStack;
      3'b010:  a.verdict = VerdictQueue;
      3'b100:  a.verdict = VerdictPriority;
      default: a.verdict = VerdictNotSure;
    endcase
    if (last) clear_orderings();
    return a;
  endfunction

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one request, holding it until the block accepts it. Valid stays
  // high into the next request unless a gap is drawn.
  task automatic send_request(logic cmd, data_t v, logic last);
    int g;
    g = gap_cycles();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= v;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  // At acceptance the predictor runs, so expectations line up with order.
  // A directed row with a typed-in answer is held to that answer instead.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && s_tvalid && s_tready) begin
      want = classify(s_tuser, s_tdata, s_tlast);
      if (use_fixed) want = fixed_answer;
      expected_answers.push_back(want);
      if (s_tuser == CmdPop) pops_sent++;
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = answer_t'(m_tdata[6:0]);
      answers_seen++;
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %h", m_tdata);
      end else begin
        want = expected_answers.pop_front();
        if (got !== want || m_tdata[7] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d expected s%b q%b h%b v%0d o%b",
                      " got s%b q%b h%b v%0d o%b"},
                     answers_seen, want.stack_ok, want.queue_ok, want.heap_ok,
                     want.verdict, want.overflow, got.stack_ok, got.queue_ok,
                     got.heap_ok, got.verdict, got.overflow);
        end
      end
    end
  end

  // The receiver stalls at random, with clean stretches in between.
  initial begin
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      g = gap_cycles();
      if (g > 0) begin
        m_tready <= 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // A case: pushes, then pops in stack, queue, max-heap or shuffled order.
  task automatic send_case();
    data_t vals[$];
    data_t order[$];
    data_t v;
    int n;
    int kind;
    int k;
    n = $urandom_range(1, 8);
    kind = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      v = ($urandom_range(0, 3) == 0) ? data_t'($urandom_range(0, 3)) : data_t'($urandom);
      vals.push_back(v);
      send_request(CmdPush, v, 1'b0);
    end
    order = vals;
    if (kind == 0) order.reverse();
    else if (kind == 2) order.rsort();
    else if (kind == 3) order.shuffle();
    k = $urandom_range(0, n);
    for (int i = 0; i < k; i++) begin
      v = order[i];
      if ($urandom_range(0, 15) == 0) v = v ^ data_t'(1 << $urandom_range(0, 15));
      send_request(CmdPop, v, 1'b0);
    end
    send_request(CmdPop, data_t'($urandom), 1'b1);
  endtask

  row_t directed[$];

  function automatic row_t mk(logic cmd, data_t v, logic last, logic fx = 0,
                              logic s = 0, logic q = 0, logic h = 0,
                              verdict_t vd = VerdictNotSure, logic o = 0);
    row_t r;
    r.cmd = cmd; r.value = v; r.last = last; r.has_fixed = fx;
    r.fixed.stack_ok = s;
    r.fixed.queue_ok = q;
    r.fixed.heap_ok = h;
    r.fixed.verdict = vd;
    r.fixed.overflow = o;
    return r;
  endfunction

  initial begin
    clear_orderings();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table. Pop from empty after reset clears every flag.
    directed.push_back(mk(CmdPop, 16'h0000, 1'b1, 1, 0, 0, 0, VerdictImpossible, 0));
    directed.push_back(mk(CmdPush, 16'hFFFF, 1'b0, 1, 1, 1, 1, VerdictNotSure, 0));
    directed.push_back(mk(CmdPush, 16'h0000, 1'b0, 1, 1, 1, 1, VerdictNotSure, 0));
    directed.push_back(mk(CmdPop, 16'hFFFF, 1'b0, 1, 0, 1, 1, VerdictNotSure, 0));
    directed.push_back(mk(CmdPop, 16'h0000, 1'b1, 1, 0, 1, 1, VerdictNotSure, 0));
    // Stack and priority queue, not queue.
    directed.push_back(mk(CmdPush, 16'h0001, 1'b0));
    directed.push_back(mk(CmdPush, 16'h0002, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0002, 1'b0, 1, 1, 0, 1, VerdictNotSure, 0));
    directed.push_back(mk(CmdPush, 16'h0003, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0003, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0001, 1'b1));
    // Queue only, with equal values in the heap.
    directed.push_back(mk(CmdPush, 16'h0005, 1'b0));
    directed.push_back(mk(CmdPush, 16'h0005, 1'b0));
    directed.push_back(mk(CmdPush, 16'h0009, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0005, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0005, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0009, 1'b1));
    // Priority queue only, then pops that match no ordering.
    directed.push_back(mk(CmdPush, 16'h0004, 1'b0));
    directed.push_back(mk(CmdPush, 16'h8000, 1'b0));
    directed.push_back(mk(CmdPush, 16'h0007, 1'b0));
    directed.push_back(mk(CmdPop, 16'h8000, 1'b0));
    directed.push_back(mk(CmdPop, 16'h0007, 1'b0));
    directed.push_back(mk(CmdPop, 16'h1234, 1'b0));
    directed.push_back(mk(CmdPop, 16'h5555, 1'b1, 1, 0, 0, 0, VerdictImpossible, 0));

    foreach (directed[i]) begin
      use_fixed = directed[i].has_fixed;
      fixed_answer = directed[i].fixed;
      send_request(directed[i].cmd, directed[i].value, directed[i].last);
    end
    use_fixed = 1'b0;

    // Random part: mostly well-formed cases, some noise.
    while (requests_sent < TotalRequests) begin
      if ($urandom_range(0, 4) != 0) begin
        send_case();
      end else begin
        send_request(logic'($urandom_range(0, 1)), data_t'($urandom),
                     logic'($urandom_range(0, 7) == 0));
      end
    end
    send_request(CmdPush, 16'h0000, 1'b1);
    s_tvalid <= 1'b0;

    while (expected_answers.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Ran the directed table and random stack, queue and heap traces.");
    $display("Checked %0d results from %0d requests, %0d of them pops.",
             answers_seen, requests_sent, pops_sent);
    if (mismatches == 0 && expected_answers.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
